@@ rtl/core/petri_net_inhibitor_fire_core_macros.svh @@
// Assertion macros shared by the Petri-net firing core.
`ifndef PETRI_NET_INHIBITOR_FIRE_CORE_MACROS_SVH
`define PETRI_NET_INHIBITOR_FIRE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PNIF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PNIF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pnif_pkg.sv @@
// Shared types, codes and widths of the Petri-net firing core.
`default_nettype none

package pnif_pkg;

  // Parameter defaults
  localparam int MAX_PLACES_DEF      = 32;
  localparam int MAX_TRANSITIONS_DEF = 64;
  localparam int TOKEN_BITS_DEF      = 8;

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int TRANS_W  = 6;
  localparam int PLACE_W  = 5;
  localparam int WEIGHT_W = 3;
  localparam int TOKCNT_W = 8;
  localparam int STATUS_W = 2;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration registers
  localparam int AP_W = 6;
  localparam int AT_W = 7;
  localparam logic [AP_W-1:0] AP_RESET = 6'd32;
  localparam logic [AT_W-1:0] AT_RESET = 7'd64;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PLACES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TRANS  = 1'd1;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_FIRE   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_TEST   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_WR_ARC = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_WR_INH = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_WR_TOK = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_RD_TOK = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_EN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_SAT    = 2'd3;

  // One request
  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic [TRANS_W-1:0]         transition;
    logic [PLACE_W-1:0]         place;
    logic signed [WEIGHT_W-1:0] arc_weight;
    logic                       inhibit_arc;
    logic [TOKCNT_W-1:0]        tokens;
  } item_t;

  // One result
  typedef struct packed {
    logic                enabled;
    logic                fired;
    logic [TOKCNT_W-1:0] token_count;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/pnif_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module pnif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/pnif_seq.sv @@
// Request sequencer: marking and arc memories, enable check and firing walk.
`default_nettype none
`include "petri_net_inhibitor_fire_core_macros.svh"

module pnif_seq #(
  parameter int MAX_PLACES      = pnif_pkg::MAX_PLACES_DEF,
  parameter int MAX_TRANSITIONS = pnif_pkg::MAX_TRANSITIONS_DEF,
  parameter int TOKEN_BITS      = pnif_pkg::TOKEN_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_ready,
  input  wire pnif_pkg::item_t                       item,
  input  wire logic [$clog2(MAX_PLACES+1)-1:0]       walk_count,
  input  wire logic [$clog2(MAX_TRANSITIONS+1)-1:0]  trans_limit,
  output logic                                       res_valid,
  input  wire logic                                  res_ready,
  output pnif_pkg::result_t                          res
);

  import pnif_pkg::*;

  localparam int PW    = $clog2(MAX_PLACES);
  localparam int CW    = $clog2(MAX_PLACES + 1);
  localparam int ARC_N = MAX_PLACES * MAX_TRANSITIONS;
  localparam int AW    = $clog2(ARC_N);
  localparam int VW    = ((TOKEN_BITS > WEIGHT_W) ? TOKEN_BITS : WEIGHT_W) + 2;
  localparam int ARC_W = WEIGHT_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_UPDATE,
    S_ARC_RD,
    S_ARC_WR,
    S_TOK_WR,
    S_TOK_RD,
    S_TOK_CAP,
    S_RESULT
  } state_t;

  state_t state;

  // Clearing pass counter
  logic [AW-1:0] clr_addr;

  // Captured request
  logic [OPCODE_W-1:0]        op;
  logic [TRANS_W-1:0]         t_idx;
  logic [PW-1:0]              p_idx;
  logic signed [WEIGHT_W-1:0] wt;
  logic                       inh;
  logic [TOKEN_BITS-1:0]      tok;

  // Walk control
  logic [AW-1:0] arc_addr;
  logic [CW-1:0] cnt;
  logic          pend;
  logic [PW-1:0] q;
  logic          ok;
  result_t       acc;

  // Memory ports
  logic                  mk_we;
  logic [PW-1:0]         mk_waddr;
  logic [TOKEN_BITS-1:0] mk_wdata;
  logic [PW-1:0]         mk_raddr;
  logic [TOKEN_BITS-1:0] mk_rdata;
  logic                  arc_we;
  logic [AW-1:0]         arc_waddr;
  logic [ARC_W-1:0]      arc_wdata;
  logic [ARC_W-1:0]      arc_rdata;

  // Decode helpers
  logic                  issue;
  logic                  t_ok;
  logic                  p_ok;
  logic [AW-1:0]         arc_start;
  state_t                dec_state;
  logic [STATUS_W-1:0]   dec_status;
  logic [WEIGHT_W-1:0]   rd_w;
  logic                  rd_inh;
  logic [VW-1:0]         v;
  logic                  blocked;
  logic                  over;
  logic [TOKEN_BITS-1:0] upd;

  pnif_ram #(
    .WIDTH (TOKEN_BITS),
    .DEPTH (MAX_PLACES)
  ) u_marking (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .raddr (mk_raddr),
    .rdata (mk_rdata)
  );

  // Arc word: {inhibitor bit, signed weight}, address place*MAX_TRANSITIONS+transition
  pnif_ram #(
    .WIDTH (ARC_W),
    .DEPTH (ARC_N)
  ) u_arcs (
    .clk   (clk),
    .we    (arc_we),
    .waddr (arc_waddr),
    .wdata (arc_wdata),
    .raddr (arc_addr),
    .rdata (arc_rdata)
  );

  assign item_ready = (state == S_IDLE);
  assign issue      = (cnt < walk_count);
  assign t_ok       = (int'(item.transition) < int'(trans_limit));
  assign p_ok       = (int'(item.place) < MAX_PLACES);
  assign arc_start  = AW'(int'(item.place) * MAX_TRANSITIONS + int'(item.transition));

  // Request decode: first state and status of an accepted transaction
  always_comb begin
    dec_state  = S_RESULT;
    dec_status = STAT_OK;
    case (item.opcode)
      OP_FIRE, OP_TEST: begin
        if (!t_ok) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_state = S_CHECK;
        end
      end
      OP_WR_ARC, OP_WR_INH: begin
        if (!t_ok || !p_ok) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_state = S_ARC_RD;
        end
      end
      OP_WR_TOK: begin
        if (!p_ok) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_state = S_TOK_WR;
        end
      end
      OP_RD_TOK: begin
        if (!p_ok) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_state = S_TOK_RD;
        end
      end
      default: dec_status = STAT_RANGE;
    endcase
  end

  // Per-place evaluation of the data read last cycle
  assign rd_w    = arc_rdata[WEIGHT_W-1:0];
  assign rd_inh  = arc_rdata[WEIGHT_W];
  assign v       = {{(VW-TOKEN_BITS){1'b0}}, mk_rdata}
                 + {{(VW-WEIGHT_W){rd_w[WEIGHT_W-1]}}, rd_w};
  assign blocked = v[VW-1] || (rd_inh && (mk_rdata != '0));
  assign over    = !v[VW-1] && (v[VW-2:TOKEN_BITS] != '0);

  always_comb begin
    if (over) begin
      upd = {TOKEN_BITS{1'b1}};
    end else if (v[VW-1]) begin
      upd = '0;
    end else begin
      upd = v[TOKEN_BITS-1:0];
    end
  end

  // Marking memory port control
  always_comb begin
    mk_we    = 1'b0;
    mk_waddr = p_idx;
    mk_wdata = tok;
    mk_raddr = p_idx;
    case (state)
      S_CLEAR: begin
        if (int'(clr_addr) < MAX_PLACES) begin
          mk_we    = 1'b1;
          mk_waddr = clr_addr[PW-1:0];
          mk_wdata = '0;
        end
      end
      S_CHECK: begin
        mk_raddr = cnt[PW-1:0];
      end
      S_UPDATE: begin
        mk_raddr = cnt[PW-1:0];
        mk_we    = pend;
        mk_waddr = q;
        mk_wdata = upd;
      end
      S_TOK_WR: begin
        mk_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Arc memory write control: clearing pass or read-modify-write of one field
  always_comb begin
    arc_we    = 1'b0;
    arc_waddr = arc_addr;
    if (op == OP_WR_ARC) begin
      arc_wdata = {arc_rdata[WEIGHT_W], wt};
    end else begin
      arc_wdata = {inh, arc_rdata[WEIGHT_W-1:0]};
    end
    case (state)
      S_CLEAR: begin
        arc_we    = 1'b1;
        arc_waddr = clr_addr;
        arc_wdata = '0;
      end
      S_ARC_WR: begin
        arc_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      if ((state == S_RESULT) && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(ARC_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            op    <= item.opcode;
            t_idx <= item.transition;
            p_idx <= PW'(item.place);
            wt    <= item.arc_weight;
            inh   <= item.inhibit_arc;
            tok   <= TOKEN_BITS'(item.tokens);
            cnt   <= '0;
            pend  <= 1'b0;
            ok    <= 1'b1;
            if ((item.opcode == OP_WR_ARC) || (item.opcode == OP_WR_INH)) begin
              arc_addr <= arc_start;
            end else begin
              arc_addr <= AW'(item.transition);
            end
            acc   <= '{enabled: 1'b0, fired: 1'b0, token_count: '0, status: dec_status};
            state <= dec_state;
          end
        end
        S_CHECK: begin
          // issue one place per cycle, evaluate it the cycle after
          pend <= issue;
          if (issue) begin
            cnt      <= cnt + 1'b1;
            arc_addr <= arc_addr + AW'(MAX_TRANSITIONS);
          end
          if (pend && blocked) begin
            ok <= 1'b0;
          end
          if (!issue && !pend) begin
            cnt      <= '0;
            arc_addr <= AW'(t_idx);
            if (!ok) begin
              acc.status <= STAT_NOT_EN;
              state      <= S_RESULT;
            end else begin
              acc.enabled <= 1'b1;
              if (op == OP_FIRE) begin
                acc.fired <= 1'b1;
                state     <= S_UPDATE;
              end else begin
                state <= S_RESULT;
              end
            end
          end
        end
        S_UPDATE: begin
          // write back place q while place q+1 is read
          pend <= issue;
          if (issue) begin
            cnt      <= cnt + 1'b1;
            arc_addr <= arc_addr + AW'(MAX_TRANSITIONS);
            q        <= cnt[PW-1:0];
          end
          if (pend && over) begin
            acc.status <= STAT_SAT;
          end
          if (!issue && !pend) begin
            state <= S_RESULT;
          end
        end
        S_ARC_RD:  state <= S_ARC_WR;
        S_ARC_WR:  state <= S_RESULT;
        S_TOK_WR:  state <= S_RESULT;
        S_TOK_RD:  state <= S_TOK_CAP;
        S_TOK_CAP: begin
          acc.token_count <= TOKCNT_W'(mk_rdata);
          state           <= S_RESULT;
        end
        S_RESULT: begin
          if (!res_valid || res_ready) begin
            res   <= acc;
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `PNIF_ASSERT_IMP(a_fired_needs_enable, res_valid && res.fired, res.enabled, "fired but not enabled")
  `PNIF_ASSERT_IMP(a_sat_needs_fire, res_valid && (res.status == STAT_SAT), res.fired, "saturation without firing")
  `PNIF_ASSERT_IMP(a_update_ports_apart, (state == S_UPDATE) && mk_we, mk_waddr != mk_raddr, "marking write and read collide")
  `PNIF_ASSERT_NXT(a_accept_leaves_idle, item_valid && item_ready, state != S_IDLE, "request accepted but sequencer idle")

endmodule

`default_nettype wire

@@ rtl/core/petri_net_inhibitor_fire_core.sv @@
// One request at a time: s_axis_tready is high only while the sequencer is idle, so a new
// request is taken only once the result of the last one has been registered.
// Reset is synchronous; after it a clearing pass zeroes both memories while
// s_axis_tready stays low; configuration writes go on meanwhile.
// Top level of the Petri-net firing core: stream ports, configuration registers.
`default_nettype none

module petri_net_inhibitor_fire_core #(
  parameter int MAX_PLACES      = pnif_pkg::MAX_PLACES_DEF,
  parameter int MAX_TRANSITIONS = pnif_pkg::MAX_TRANSITIONS_DEF,
  parameter int TOKEN_BITS      = pnif_pkg::TOKEN_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // request stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // transition[5:0], place[10:6], arc_weight[13:11], inhibit_arc[14], tokens[22:15]
  input  wire logic [pnif_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // opcode[2:0]
  input  wire logic [pnif_pkg::IN_USER_W-1:0]     s_axis_tuser,
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // enabled[0], fired[1], token_count[9:2], status[11:10]
  output logic [pnif_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pnif_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pnif_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import pnif_pkg::*;

  localparam int PCW = $clog2(MAX_PLACES + 1);
  localparam int TLW = $clog2(MAX_TRANSITIONS + 1);

  logic [AP_W-1:0] active_places;
  logic [AT_W-1:0] active_transitions;
  logic [PCW-1:0]  walk_count;
  logic [TLW-1:0]  trans_limit;
  item_t           item;
  result_t         res;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_places      <= AP_RESET;
      active_transitions <= AT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_PLACES: active_places      <= cfg_data[AP_W-1:0];
        CFG_ACTIVE_TRANS:  active_transitions <= cfg_data[AT_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit the registers to the sizes built
  always_comb begin
    if (int'(active_places) > MAX_PLACES) begin
      walk_count = PCW'(MAX_PLACES);
    end else begin
      walk_count = PCW'(active_places);
    end
    if (int'(active_transitions) > MAX_TRANSITIONS) begin
      trans_limit = TLW'(MAX_TRANSITIONS);
    end else begin
      trans_limit = TLW'(active_transitions);
    end
  end

  // Request unpacking
  assign item.opcode      = s_axis_tuser;
  assign item.transition  = s_axis_tdata[5:0];
  assign item.place       = s_axis_tdata[10:6];
  assign item.arc_weight  = s_axis_tdata[13:11];
  assign item.inhibit_arc = s_axis_tdata[14];
  assign item.tokens      = s_axis_tdata[22:15];

  pnif_seq #(
    .MAX_PLACES      (MAX_PLACES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS),
    .TOKEN_BITS      (TOKEN_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s_axis_tvalid),
    .item_ready  (s_axis_tready),
    .item        (item),
    .walk_count  (walk_count),
    .trans_limit (trans_limit),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  // Result packing
  assign m_axis_tdata = {4'b0000, res.status, res.token_count, res.fired, res.enabled};

endmodule

`default_nettype wire
